// File: rtl/tdbpe_pkg.sv
// Shared types and constants for the tape data block pulse encoder.
`default_nettype none

package tdbpe_pkg;

  localparam int unsigned TicksW = 28;
  localparam int unsigned CountW = 16;
  localparam int unsigned LenW   = 16;

  localparam logic [TicksW-1:0] TICKS_PER_MS   = 28'd3500;
  localparam logic [TicksW-1:0] TICKS_MAX      = 28'd229372500;
  localparam logic [CountW-1:0] STD_PILOT_LONG  = 16'd8063;
  localparam logic [CountW-1:0] STD_PILOT_SHORT = 16'd3223;
  localparam logic [7:0]        FLAG_THRESHOLD  = 8'd128;
  localparam logic [3:0]        BITS_PER_BYTE   = 4'd8;

  typedef enum logic [2:0] {
    REG_LEADER_MODE  = 3'd0,
    REG_PILOT_COUNT  = 3'd1,
    REG_PILOT_LENGTH = 3'd2,
    REG_SYNC_FIRST   = 3'd3,
    REG_SYNC_SECOND  = 3'd4,
    REG_ZERO_LENGTH  = 3'd5,
    REG_ONE_LENGTH   = 3'd6,
    REG_PAUSE_MS     = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    LEADER_NONE  = 2'd0,
    LEADER_FIXED = 2'd1,
    LEADER_FLAG  = 2'd2,
    LEADER_RSVD  = 2'd3
  } leader_mode_e;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_PILOT = 7'b0000010,
    PH_SYNC1 = 7'b0000100,
    PH_SYNC2 = 7'b0001000,
    PH_BITS  = 7'b0010000,
    PH_GAP_A = 7'b0100000,
    PH_GAP_B = 7'b1000000
  } phase_e;

  typedef struct packed {
    leader_mode_e      leader_mode;
    logic [CountW-1:0] pilot_count;
    logic [LenW-1:0]   pilot_ticks;
    logic [LenW-1:0]   sync_first_length;
    logic [LenW-1:0]   sync_second_length;
    logic [LenW-1:0]   zero_length;
    logic [LenW-1:0]   one_length;
    logic [LenW-1:0]   pause_ms;
    logic [TicksW-1:0] gap_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/tdbpe_cfg.sv
// Configuration register file with precomputed gap length in ticks.
`default_nettype none

module tdbpe_cfg
  import tdbpe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic [TicksW-1:0] gap_ticks_d;

  assign gap_ticks_d = TicksW'(cfg_wdata_i) * TICKS_PER_MS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_mode        <= LEADER_FLAG;
      cfg_q.pilot_count        <= 16'd8063;
      cfg_q.pilot_ticks        <= 16'd2168;
      cfg_q.sync_first_length  <= 16'd667;
      cfg_q.sync_second_length <= 16'd735;
      cfg_q.zero_length        <= 16'd855;
      cfg_q.one_length         <= 16'd1710;
      cfg_q.pause_ms           <= 16'd0;
      cfg_q.gap_ticks          <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_LEADER_MODE:  cfg_q.leader_mode        <= leader_mode_e'(cfg_wdata_i[1:0]);
        REG_PILOT_COUNT:  cfg_q.pilot_count        <= cfg_wdata_i;
        REG_PILOT_LENGTH: cfg_q.pilot_ticks        <= cfg_wdata_i;
        REG_SYNC_FIRST:   cfg_q.sync_first_length  <= cfg_wdata_i;
        REG_SYNC_SECOND:  cfg_q.sync_second_length <= cfg_wdata_i;
        REG_ZERO_LENGTH:  cfg_q.zero_length        <= cfg_wdata_i;
        REG_ONE_LENGTH:   cfg_q.one_length         <= cfg_wdata_i;
        REG_PAUSE_MS: begin
          cfg_q.pause_ms  <= cfg_wdata_i;
          cfg_q.gap_ticks <= gap_ticks_d;
        end
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/tape_data_block_pulse_encoder.sv
// Top level: turns tape data bytes into runs of alternating-level pulses.
// Each byte is held in the byte state registers; its runs leave through the output register.
// Throughput: one run per cycle while the output is not stalled; a byte has as many runs
// as its phases need (8 for a middle byte, up to 13, or none at all).
// Reset: asynchronous, active low; clears config registers to defaults, phase to idle, output valid low, line low.
`default_nettype none

module tape_data_block_pulse_encoder
  import tdbpe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // data_byte[7:0], bits_used[11:8], zero pad
  input  wire logic        s_axis_tuser,  // block_start
  input  wire logic        s_axis_tlast,  // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // start_level[0], pulse_ticks[28:1],
                                          // pulse_count[44:29], zero pad
  output logic             m_axis_tlast   // run_last
);

  cfg_t cfg;

  tdbpe_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Held byte state
  phase_e            phase_q, phase_d;
  logic [7:0]        byte_q;
  logic [3:0]        bits_left_q;
  logic              gap_q;
  logic [CountW-1:0] pcnt_q;
  logic              level_q;

  // Output register
  logic              ovalid_q;
  logic              olevel_q;
  logic [TicksW-1:0] oticks_q;
  logic [CountW-1:0] ocount_q;
  logic              olast_q;

  logic              in_fire;
  logic              run_fire;
  logic [7:0]        in_byte;
  logic [3:0]        in_used;
  logic              in_lead;
  logic [CountW-1:0] in_pcnt;
  logic [3:0]        in_nbits;
  logic              in_gap;
  phase_e            start_ph;

  phase_e            nxt_ph;
  phase_e            after_lead;
  logic [TicksW-1:0] run_ticks;
  logic [CountW-1:0] run_count;
  logic              split;

  assign in_byte = s_axis_tdata[7:0];
  assign in_used = s_axis_tdata[11:8];

  assign run_fire = (phase_q != PH_IDLE) && (!ovalid_q || m_axis_tready);
  assign s_axis_tready = (phase_q == PH_IDLE) || (run_fire && (nxt_ph == PH_IDLE));
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Start of a new byte
  always_comb begin
    in_lead = s_axis_tuser &&
              (cfg.leader_mode == LEADER_FIXED || cfg.leader_mode == LEADER_FLAG);
    if (cfg.leader_mode == LEADER_FIXED) begin
      in_pcnt = cfg.pilot_count;
    end else if (in_byte < FLAG_THRESHOLD) begin
      in_pcnt = STD_PILOT_LONG;
    end else begin
      in_pcnt = STD_PILOT_SHORT;
    end
    if (!s_axis_tlast) begin
      in_nbits = BITS_PER_BYTE;
    end else if (in_used > BITS_PER_BYTE) begin
      in_nbits = BITS_PER_BYTE;
    end else begin
      in_nbits = in_used;
    end
    in_gap = s_axis_tlast && (cfg.pause_ms != '0);
    priority if (in_lead && in_pcnt != '0) begin
      start_ph = PH_PILOT;
    end else if (in_lead) begin
      start_ph = PH_SYNC1;
    end else if (in_nbits != '0) begin
      start_ph = PH_BITS;
    end else if (in_gap) begin
      start_ph = PH_GAP_A;
    end else begin
      start_ph = PH_IDLE;
    end
  end

  // Current run and next phase
  always_comb begin
    if (bits_left_q != '0) begin
      after_lead = PH_BITS;
    end else if (gap_q) begin
      after_lead = PH_GAP_A;
    end else begin
      after_lead = PH_IDLE;
    end
    split     = (cfg.pause_ms > 16'd1) && !level_q;
    run_ticks = '0;
    run_count = 16'd1;
    nxt_ph    = PH_IDLE;
    unique case (phase_q)
      PH_PILOT: begin
        run_ticks = TicksW'(cfg.pilot_ticks);
        run_count = pcnt_q;
        nxt_ph    = PH_SYNC1;
      end
      PH_SYNC1: begin
        run_ticks = TicksW'(cfg.sync_first_length);
        nxt_ph    = PH_SYNC2;
      end
      PH_SYNC2: begin
        run_ticks = TicksW'(cfg.sync_second_length);
        nxt_ph    = after_lead;
      end
      PH_BITS: begin
        run_ticks = byte_q[7] ? TicksW'(cfg.one_length) : TicksW'(cfg.zero_length);
        run_count = 16'd2;
        if (bits_left_q > 4'd1) begin
          nxt_ph = PH_BITS;
        end else if (gap_q) begin
          nxt_ph = PH_GAP_A;
        end else begin
          nxt_ph = PH_IDLE;
        end
      end
      PH_GAP_A: begin
        run_ticks = split ? TICKS_PER_MS : cfg.gap_ticks;
        nxt_ph    = split ? PH_GAP_B : PH_IDLE;
      end
      PH_GAP_B: begin
        run_ticks = cfg.gap_ticks - TICKS_PER_MS;
      end
      default: begin
        run_count = '0;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    if (in_fire) begin
      phase_d = start_ph;
    end else if (run_fire) begin
      phase_d = nxt_ph;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      level_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (run_fire) begin
        level_q  <= level_q ^ run_count[0];
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byte_q      <= in_byte;
      bits_left_q <= in_nbits;
      gap_q       <= in_gap;
      pcnt_q      <= in_pcnt;
    end else if (run_fire && phase_q == PH_BITS) begin
      byte_q      <= {byte_q[6:0], 1'b0};
      bits_left_q <= bits_left_q - 4'd1;
    end
    if (run_fire) begin
      olevel_q <= level_q;
      oticks_q <= run_ticks;
      ocount_q <= run_count;
      olast_q  <= (nxt_ph == PH_IDLE);
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, ocount_q, oticks_q, olevel_q};
  assign m_axis_tlast  = olast_q;

`ifndef ASSERT_OFF
  a_busy_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (phase_q != PH_IDLE))
    else $error("input stalled with no byte in progress");

  a_bit_keeps_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_fire && phase_q == PH_BITS) |=> (level_q == $past(level_q)))
    else $error("bit run changed line level");

  a_ticks_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_fire && (phase_q == PH_GAP_A || phase_q == PH_GAP_B)) |-> (run_ticks <= TICKS_MAX))
    else $error("gap length out of range");

  a_split_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_GAP_B) |-> (cfg.pause_ms > 16'd1))
    else $error("split gap without long pause");
`endif

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the tape data block pulse encoder: predicts pulse runs per byte.
module testbench
  import tdbpe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_TICKS = 20;
  localparam int RANDOM_ITEMS = 310;

  typedef struct packed {
    logic              start_level;
    logic [TicksW-1:0] pulse_ticks;
    logic [CountW-1:0] pulse_count;
    logic              run_last;
  } pulse_run_t;

  typedef struct packed {
    leader_mode_e    mode;
    logic [LenW-1:0] pilot_count;
    logic [LenW-1:0] pilot_ticks;
    logic [LenW-1:0] sync_first;
    logic [LenW-1:0] sync_second;
    logic [LenW-1:0] zero_length;
    logic [LenW-1:0] one_length;
    logic [LenW-1:0] pause_ms;
  } enc_cfg_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  tape_data_block_pulse_encoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  enc_cfg_t   cur_cfg;
  logic       line_lvl;
  pulse_run_t exp_runs[$];
  pulse_run_t pending[$];

  int  mismatches    = 0;
  int  bytes_sent    = 0;
  int  runs_seen     = 0;
  int  cfgs_applied  = 0;
  int  items_random  = 0;
  int  cycles        = 0;
  int  hold_req      = 0;
  bit  tx_gaps       = 1'b1;
  bit  rx_stalls     = 1'b1;
  int  tx_burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  function automatic enc_cfg_t default_cfg();
    enc_cfg_t c;
    c.mode         = LEADER_FLAG;
    c.pilot_count  = STD_PILOT_LONG;
    c.pilot_ticks  = 16'd2168;
    c.sync_first   = 16'd667;
    c.sync_second  = 16'd735;
    c.zero_length  = 16'd855;
    c.one_length   = 16'd1710;
    c.pause_ms     = 16'd0;
    return c;
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 4000));
    endcase
  endfunction

  function automatic enc_cfg_t random_cfg();
    enc_cfg_t c;
    c.mode         = leader_mode_e'($urandom_range(0, 3));
    c.pilot_count  = ($urandom_range(0, 3) == 0) ? pick_len() : 16'($urandom);
    c.pilot_ticks  = pick_len();
    c.sync_first   = pick_len();
    c.sync_second  = pick_len();
    c.zero_length  = pick_len();
    c.one_length   = pick_len();
    case ($urandom_range(0, 5))
      0: c.pause_ms = 16'd0;
      1: c.pause_ms = 16'd1;
      2: c.pause_ms = 16'd2;
      3: c.pause_ms = 16'hFFFF;
      default: c.pause_ms = 16'($urandom_range(3, 50));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_run(logic [TicksW-1:0] ticks, logic [CountW-1:0] count);
    pulse_run_t r;
    r.start_level = line_lvl;
    r.pulse_ticks = ticks;
    r.pulse_count = count;
    r.run_last    = 1'b0;
    pending = {pending, r};
    line_lvl = line_lvl ^ count[0];
  endfunction

  function automatic void predict_runs(logic [7:0] b, bit is_first, bit is_last,
                                       logic [3:0] used);
    logic [CountW-1:0] pilot_n;
    int                nbits;
    pending.delete();
    if (is_first && (cur_cfg.mode == LEADER_FIXED || cur_cfg.mode == LEADER_FLAG)) begin
      if (cur_cfg.mode == LEADER_FIXED) pilot_n = cur_cfg.pilot_count;
      else pilot_n = (b < FLAG_THRESHOLD) ? STD_PILOT_LONG : STD_PILOT_SHORT;
      if (pilot_n != 0) add_run(TicksW'(cur_cfg.pilot_ticks), pilot_n);
      add_run(TicksW'(cur_cfg.sync_first), 16'd1);
      add_run(TicksW'(cur_cfg.sync_second), 16'd1);
    end
    nbits = 8;
    if (is_last) nbits = (used > BITS_PER_BYTE) ? 8 : int'(used);
    for (int i = 0; i < nbits; i++) begin
      add_run(TicksW'(b[7-i] ? cur_cfg.one_length : cur_cfg.zero_length), 16'd2);
    end
    if (is_last && cur_cfg.pause_ms != 0) begin
      if (cur_cfg.pause_ms > 1 && line_lvl == 1'b0) begin
        add_run(TICKS_PER_MS, 16'd1);
        add_run(TicksW'(cur_cfg.pause_ms - 16'd1) * TICKS_PER_MS, 16'd1);
      end else begin
        add_run(TicksW'(cur_cfg.pause_ms) * TICKS_PER_MS, 16'd1);
      end
    end
    if (pending.size() > 0) pending[pending.size() - 1].run_last = 1'b1;
    exp_runs = {exp_runs, pending};
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at run %0d: %s", runs_seen, msg);
  endtask

  task automatic check_run();
    pulse_run_t got;
    pulse_run_t want;
    got.start_level = m_axis_tdata[0];
    got.pulse_ticks = m_axis_tdata[28:1];
    got.pulse_count = m_axis_tdata[44:29];
    got.run_last    = m_axis_tlast;
    runs_seen++;
    if (exp_runs.size() == 0) begin
      report_mismatch($sformatf("unexpected run ticks=%0d count=%0d",
                                got.pulse_ticks, got.pulse_count));
      return;
    end
    want = exp_runs.pop_front();
    if (got.start_level !== want.start_level)
      report_mismatch($sformatf("start_level %b, want %b", got.start_level, want.start_level));
    if (got.pulse_ticks !== want.pulse_ticks)
      report_mismatch($sformatf("pulse_ticks %0d, want %0d", got.pulse_ticks, want.pulse_ticks));
    if (got.pulse_count !== want.pulse_count)
      report_mismatch($sformatf("pulse_count %0d, want %0d", got.pulse_count, want.pulse_count));
    if (got.run_last !== want.run_last)
      report_mismatch($sformatf("run_last %b, want %b", got.run_last, want.run_last));
  endtask

  initial begin
    int rdy_left;
    int stall_left;
    int hold_left;
    rdy_left   = 0;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_run();
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!rx_stalls) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (rdy_left > 0) begin
        rdy_left--;
        m_axis_tready <= 1'b1;
      end else begin
        rdy_left   = $urandom_range(0, 11);
        stall_left = $urandom_range(1, 5);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Called and returns at a falling edge; leaves tvalid high after the beat.
  task automatic push_byte(logic [7:0] b, bit is_first, bit is_last, logic [3:0] used);
    int gap;
    if (tx_gaps) begin
      if (tx_burst_left == 0) begin
        gap           = $urandom_range(1, 6);
        tx_burst_left = $urandom_range(1, 10);
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 16'($urandom);
        repeat (gap) @(negedge clk_i);
      end
      tx_burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, used, b};
    s_axis_tuser  <= is_first;
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_runs(b, is_first, is_last, used);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (exp_runs.size() != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
  endtask

  task automatic set_config(enc_cfg_t c);
    logic [13:0] junk;
    junk = 14'($urandom);
    write_reg(REG_LEADER_MODE, {junk, c.mode});
    write_reg(REG_PILOT_COUNT, c.pilot_count);
    write_reg(REG_PILOT_LENGTH, c.pilot_ticks);
    write_reg(REG_SYNC_FIRST, c.sync_first);
    write_reg(REG_SYNC_SECOND, c.sync_second);
    write_reg(REG_ZERO_LENGTH, c.zero_length);
    write_reg(REG_ONE_LENGTH, c.one_length);
    write_reg(REG_PAUSE_MS, c.pause_ms);
    cfg_we_i <= 1'b0;
    cur_cfg = c;
    cfgs_applied++;
  endtask

  task automatic test_default_block();
    push_byte(8'h00, 1'b1, 1'b0, 4'd8);
    push_byte(8'hFF, 1'b0, 1'b0, 4'd0);
    push_byte(8'hA5, 1'b0, 1'b0, 4'd15);
    push_byte(8'h80, 1'b0, 1'b1, 4'd8);
    push_byte(8'h80, 1'b1, 1'b1, 4'd3);
    push_byte(8'h7F, 1'b1, 1'b0, 4'd8);
  endtask

  task automatic test_leader_modes();
    enc_cfg_t c;
    settle_idle();
    c = default_cfg();
    c.mode        = LEADER_FIXED;
    c.pilot_count = 16'd0;
    set_config(c);
    push_byte(8'h12, 1'b1, 1'b0, 4'd0);
    settle_idle();
    c.pilot_count  = 16'hFFFF;
    c.pilot_ticks  = 16'hFFFF;
    set_config(c);
    push_byte(8'hFF, 1'b1, 1'b1, 4'd8);
    settle_idle();
    c.mode = LEADER_NONE;
    set_config(c);
    push_byte(8'h3C, 1'b1, 1'b0, 4'd0);
    settle_idle();
    c.mode = LEADER_RSVD;
    set_config(c);
    push_byte(8'hC3, 1'b1, 1'b1, 4'd5);
  endtask

  task automatic test_last_byte_bits();
    enc_cfg_t c;
    settle_idle();
    c = default_cfg();
    c.mode = LEADER_NONE;
    set_config(c);
    push_byte(8'hAA, 1'b0, 1'b1, 4'd0);
    push_byte(8'hAA, 1'b0, 1'b1, 4'd1);
    push_byte(8'h55, 1'b0, 1'b1, 4'd9);
    push_byte(8'hF0, 1'b0, 1'b1, 4'd15);
    push_byte(8'h0F, 1'b0, 1'b1, 4'd7);
  endtask

  task automatic test_gap_rule();
    enc_cfg_t c;
    settle_idle();
    c              = default_cfg();
    c.pilot_ticks  = 16'd0;
    c.sync_first   = 16'd0;
    c.sync_second  = 16'd0;
    c.zero_length  = 16'd0;
    c.one_length   = 16'd0;
    c.pause_ms     = 16'd1;
    set_config(c);
    push_byte(8'h00, 1'b1, 1'b1, 4'd8);
    push_byte(8'h01, 1'b0, 1'b1, 4'd2);
    settle_idle();
    c.sync_first  = 16'hFFFF;
    c.sync_second = 16'hFFFF;
    c.zero_length = 16'hFFFF;
    c.one_length  = 16'hFFFF;
    c.pause_ms    = 16'd2;
    set_config(c);
    push_byte(8'h81, 1'b1, 1'b1, 4'd8);
    push_byte(8'h81, 1'b0, 1'b1, 4'd8);
    push_byte(8'h01, 1'b1, 1'b1, 4'd2);
    settle_idle();
    c.pause_ms = 16'hFFFF;
    set_config(c);
    push_byte(8'h00, 1'b0, 1'b1, 4'd0);
    push_byte(8'hFE, 1'b1, 1'b1, 4'd0);
  endtask

  task automatic test_random_blocks();
    enc_cfg_t c;
    int       n;
    bit       noise;
    while (items_random < RANDOM_ITEMS) begin
      settle_idle();
      c = random_cfg();
      set_config(c);
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      repeat (8) begin
        n     = $urandom_range(1, 6);
        noise = ($urandom_range(0, 6) == 0);
        for (int j = 0; j < n; j++) begin
          push_byte(rand_byte(),
                    noise ? 1'($urandom_range(0, 1)) : (j == 0),
                    noise ? 1'($urandom_range(0, 1)) : (j == n - 1),
                    4'($urandom_range(0, 15)));
          items_random++;
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    enc_cfg_t c;
    settle_idle();
    c          = default_cfg();
    c.pause_ms = 16'd2;
    set_config(c);
    tx_gaps  = 1'b0;
    hold_req = HOLD_CYCLES;
    repeat (6) begin
      push_byte(rand_byte(), 1'b1, 1'b0, 4'd8);
      push_byte(rand_byte(), 1'b0, 1'b0, 4'd8);
      push_byte(rand_byte(), 1'b0, 1'b0, 4'd8);
      push_byte(rand_byte(), 1'b0, 1'b1, 4'($urandom_range(0, 15)));
    end
    tx_gaps = 1'b1;
  endtask

  initial begin
    cur_cfg  = default_cfg();
    line_lvl = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_default_block();
    test_leader_modes();
    test_last_byte_bits();
    test_gap_rule();
    test_output_backpressure();
    test_random_blocks();
    settle_idle();
    $display("sent %0d bytes, checked %0d pulse runs under %0d register settings",
             bytes_sent, runs_seen, cfgs_applied);
    $display("leader modes, short last bytes, split gaps and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tdbpe_pkg.sv
rtl/tdbpe_cfg.sv
rtl/tape_data_block_pulse_encoder.sv
tb/sv/testbench.sv
